/* src/mcs_pkg.sv */
// microstep coil sequencer: shared constants, codes and the precomputed duty curve
// no dependencies; imported by microstep_coil_sequencer_unit
`default_nettype none

package mcs_pkg;

	// microsteps per full step, range 8 to 16
	localparam int MICROSTEPS_PER_STEP = 16;
	localparam int PHASE_COUNT         = 4 * MICROSTEPS_PER_STEP;
	localparam int PHASE_W             = 6;
	localparam int OFS_W               = $clog2(MICROSTEPS_PER_STEP + 1);
	localparam int DUTY_W              = 12;
	localparam int POS_W               = 16;
	localparam int PATTERN_W           = 4;

	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);

	// stream packing
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;

	typedef enum logic {
		FUNC_STEP    = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_BWD = 1'b1
	} dir_t;

	typedef enum logic {
		CFG_REV_LEN = 1'b0,
		CFG_TARGET  = 1'b1
	} cfg_idx_t;

	localparam logic [POS_W-1:0] REV_LEN_RESET = POS_W'(3200);
	localparam logic [POS_W-1:0] TARGET_RESET  = '0;

	// coil-direction pattern per quadrant
	localparam logic [PATTERN_W-1:0] PATTERN_Q0 = 4'h3;
	localparam logic [PATTERN_W-1:0] PATTERN_Q1 = 4'h6;
	localparam logic [PATTERN_W-1:0] PATTERN_Q2 = 4'hC;
	localparam logic [PATTERN_W-1:0] PATTERN_Q3 = 4'h9;
	localparam logic [PATTERN_W-1:0] PATTERN_OFF = 4'h0;

	// quarter sine, 17 points over 16 microsteps
	typedef logic [DUTY_W-1:0] sine_tab_t [0:16];
	localparam sine_tab_t QUARTER_SINE = '{
		12'd0,    12'd401,  12'd799,  12'd1189, 12'd1567, 12'd1930,
		12'd2275, 12'd2598, 12'd2896, 12'd3165, 12'd3405, 12'd3611,
		12'd3783, 12'd3919, 12'd4016, 12'd4075, 12'd4095
	};

	// curve resampled to the configured microstep count
	typedef logic [DUTY_W-1:0] curve_tab_t [0:MICROSTEPS_PER_STEP];

	function automatic curve_tab_t build_curve();
		curve_tab_t tab;
		for (int i = 0; i <= MICROSTEPS_PER_STEP; i++) begin
			tab[i] = QUARTER_SINE[(i * 16) / MICROSTEPS_PER_STEP];
		end
		return tab;
	endfunction

	localparam curve_tab_t CURVE_TAB = build_curve();

endpackage

`default_nettype wire

/* src/microstep_coil_sequencer_unit.sv */
// microstep coil sequencer top level: phase and position counters, duty lookup, output register
// depends on mcs_pkg
`default_nettype none

//  channel   | signals                              | direction | moves
//  ----------+--------------------------------------+-----------+------------------------------
//  s_axis    | tvalid, tready, tdata[7:0], tuser    | in        | step / release request
//  m_axis    | tvalid, tready, tdata[47:0]          | out       | duties, pattern, position
//  cfg       | valid, ready, index, data[15:0]      | in        | register write request
//
//  one request per clock while the output is not stalled; its result sits in the output register the cycle after accept
//  phase and position update at the accept edge, so back-to-back requests see fresh state
//  s_axis_tready drops only while a result is held and m_axis_tready is low
//  arst_n clears phase, position, output valid and reloads both config registers
//  cfg writes are always taken (cfg_ready tied high)

module microstep_coil_sequencer_unit
	import mcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] direction, [7:1] zero
	input  wire logic                  s_axis_tuser,   // [0] func

	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,   // [11:0] duty_a, [23:12] duty_b,
	                                                   // [27:24] coil_pattern,
	                                                   // [43:28] position, [44] at_target,
	                                                   // [47:45] zero

	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [POS_W-1:0]      cfg_data
);

	// config registers
	logic [POS_W-1:0] rev_len_q;
	logic [POS_W-1:0] target_q;

	// state
	logic [PHASE_W-1:0] phase_q;
	logic [POS_W-1:0]   pos_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic in_acc;
	func_t func_in;
	dir_t  dir_in;

	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] phase_step;
	logic [PHASE_W-1:0] phase_nxt;

	logic [POS_W:0]     rev_len;
	logic [POS_W:0]     rev_len_m1;
	logic [POS_W:0]     pos_inc;
	logic [POS_W-1:0]   pos_step;
	logic [POS_W-1:0]   pos_nxt;

	logic [1:0]         quad;
	logic [PHASE_W-1:0] quad_base;
	logic [OFS_W-1:0]   ofs;
	logic [OFS_W-1:0]   ofs_mirror;
	logic [DUTY_W-1:0]  curve_fwd;
	logic [DUTY_W-1:0]  curve_rev;
	logic [DUTY_W-1:0]  duty_a;
	logic [DUTY_W-1:0]  duty_b;
	logic [PATTERN_W-1:0] pattern;
	logic               at_target;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign func_in       = func_t'(s_axis_tuser);
	assign dir_in        = dir_t'(s_axis_tdata[0]);

	// phase counter, wraps at PHASE_COUNT
	always_comb begin
		phase_inc = phase_q + PHASE_W'(1);
		if (dir_in == DIR_FWD) begin
			phase_step = ({1'b0, phase_inc} >= (PHASE_W + 1)'(PHASE_COUNT)) ? '0 : phase_inc;
		end else begin
			phase_step = (phase_q == '0 || {1'b0, phase_q} >= (PHASE_W + 1)'(PHASE_COUNT))
				? PHASE_LAST : phase_q - PHASE_W'(1);
		end
		phase_nxt = (func_in == FUNC_STEP) ? phase_step : phase_q;
	end

	// position counter; a zero length means a full 16-bit revolution
	always_comb begin
		rev_len    = {(rev_len_q == '0), rev_len_q};
		rev_len_m1 = rev_len - (POS_W + 1)'(1);
		pos_inc    = {1'b0, pos_q} + (POS_W + 1)'(1);
		if (dir_in == DIR_FWD) begin
			pos_step = (pos_inc >= rev_len) ? '0 : pos_inc[POS_W-1:0];
		end else begin
			// also covers a position left beyond a lowered length
			pos_step = (pos_q == '0 || {1'b0, pos_q} > rev_len)
				? rev_len_m1[POS_W-1:0] : pos_q - POS_W'(1);
		end
		pos_nxt = (func_in == FUNC_STEP) ? pos_step : pos_q;
	end

	// quadrant and offset inside it, by compare against constant multiples
	always_comb begin
		priority if ({1'b0, phase_nxt} >= (PHASE_W + 1)'(3 * MICROSTEPS_PER_STEP)) begin
			quad      = 2'd3;
			quad_base = PHASE_W'(3 * MICROSTEPS_PER_STEP);
		end else if ({1'b0, phase_nxt} >= (PHASE_W + 1)'(2 * MICROSTEPS_PER_STEP)) begin
			quad      = 2'd2;
			quad_base = PHASE_W'(2 * MICROSTEPS_PER_STEP);
		end else if ({1'b0, phase_nxt} >= (PHASE_W + 1)'(MICROSTEPS_PER_STEP)) begin
			quad      = 2'd1;
			quad_base = PHASE_W'(MICROSTEPS_PER_STEP);
		end else begin
			quad      = 2'd0;
			quad_base = '0;
		end
	end

	always_comb begin
		logic [PHASE_W-1:0] diff;
		diff       = phase_nxt - quad_base;
		ofs        = diff[OFS_W-1:0];
		ofs_mirror = OFS_W'(MICROSTEPS_PER_STEP) - ofs;
		curve_fwd  = CURVE_TAB[ofs];
		curve_rev  = CURVE_TAB[ofs_mirror];
	end

	// even quadrants: coil A on the falling half, B rising; odd ones swap
	always_comb begin
		duty_a  = '0;
		duty_b  = '0;
		pattern = PATTERN_OFF;
		if (func_in == FUNC_STEP) begin
			duty_a = quad[0] ? curve_fwd : curve_rev;
			duty_b = quad[0] ? curve_rev : curve_fwd;
			unique case (quad)
				2'd0: pattern = PATTERN_Q0;
				2'd1: pattern = PATTERN_Q1;
				2'd2: pattern = PATTERN_Q2;
				2'd3: pattern = PATTERN_Q3;
				default: pattern = PATTERN_OFF;
			endcase
		end
	end

	assign at_target = (pos_nxt == target_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_len_q <= REV_LEN_RESET;
			target_q  <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REV_LEN: rev_len_q <= cfg_data;
				CFG_TARGET:  target_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// state update at request accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nxt;
			pos_q   <= pos_nxt;
		end
	end

	// output register: valid flag with reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= {3'b000, at_target, pos_nxt, pattern, duty_b, duty_a};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// phase never leaves its cycle
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < (PHASE_W + 1)'(PHASE_COUNT))
		else $error("phase counter out of range");

	// a release leaves phase and position alone
	a_release_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func_in == FUNC_RELEASE) |=> ($stable(phase_q) && $stable(pos_q)))
		else $error("release changed phase or position");

	// released coils carry no duty
	a_off_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[27:24] == PATTERN_OFF)
		|-> (out_data_q[23:0] == 24'd0))
		else $error("duty present with coils off");

	// a pattern drives two coil inputs or none
	a_pattern_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones(out_data_q[27:24]) == 2 ||
		                 $countones(out_data_q[27:24]) == 0))
		else $error("malformed coil pattern");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// self-checking bench for microstep_coil_sequencer_unit: a directed plan,
// then random step and release requests; depends on mcs_pkg and the unit
// keeps its own phase and position tracker to predict each coil drive result

module tb_top;
	import mcs_pkg::*;

	// one coil drive result, laid out as in m_axis_tdata from bit 0 up
	typedef struct packed {
		logic                 at_target;
		logic [POS_W-1:0]     position;
		logic [PATTERN_W-1:0] pattern;
		logic [DUTY_W-1:0]    duty_b;
		logic [DUTY_W-1:0]    duty_a;
	} coil_drive_t;

	// directed plan row: a register write, or a request with an optional hand-typed result
	typedef struct packed {
		logic             is_write;
		cfg_idx_t         reg_idx;
		logic [POS_W-1:0] reg_val;
		func_t            func;
		dir_t             dir;
		logic             typed;
		coil_drive_t      want;
	} plan_row_t;

	localparam int ITEMS_PER_PHASE = 125;
	localparam int RANDOM_PHASES   = 8;
	localparam int SHOWN_MISMATCHES = 10;

	// every input has a known value from time zero
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index     = 1'b0;
	logic [POS_W-1:0]      cfg_data      = '0;

	// tracker: phase, position and the two registers as the unit should hold them
	logic [PHASE_W-1:0] trk_phase   = '0;
	logic [POS_W-1:0]   trk_pos     = '0;
	logic [POS_W-1:0]   trk_rev_len = REV_LEN_RESET;
	logic [POS_W-1:0]   trk_target  = TARGET_RESET;

	// expected coil drive results, oldest first
	coil_drive_t drive_expect_q [$];

	int fail_count = 0;
	int stall_left = 0;
	bit calm       = 1'b0;   // no idling on either side while set

	microstep_coil_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarter sine point resampled to the microstep count, floor of i*16/M
	function automatic logic [DUTY_W-1:0] sine_point(input int i);
		int k;
		k = (i * 16) / MICROSTEPS_PER_STEP;
		if (k > 16) k = 16;
		return QUARTER_SINE[k];
	endfunction

	// apply one request to the tracker and return the coil drive it should produce
	function automatic coil_drive_t step_drive(input func_t f, input dir_t d);
		coil_drive_t res;
		int span, quad, ofs;
		res = '0;
		// a zero length means a full 16-bit revolution
		span = (trk_rev_len == '0) ? 65536 : int'(trk_rev_len);
		if (f == FUNC_STEP) begin
			if (d == DIR_FWD) begin
				trk_phase = (int'(trk_phase) + 1 >= PHASE_COUNT) ? '0 : trk_phase + 1'b1;
				// a position at or past the end goes to zero
				trk_pos = (int'(trk_pos) + 1 >= span) ? '0 : trk_pos + 1'b1;
			end else begin
				trk_phase = (trk_phase == '0 || int'(trk_phase) >= PHASE_COUNT) ?
					PHASE_LAST : trk_phase - 1'b1;
				// from zero or from beyond the end, back to the last position
				trk_pos = (trk_pos == '0 || int'(trk_pos) > span) ?
					POS_W'(span - 1) : trk_pos - 1'b1;
			end
			quad = (int'(trk_phase) / MICROSTEPS_PER_STEP) % 4;
			ofs  = int'(trk_phase) % MICROSTEPS_PER_STEP;
			// even quadrants: coil a falls while b rises; odd ones mirror it
			if (quad % 2 == 0) begin
				res.duty_a = sine_point(MICROSTEPS_PER_STEP - ofs);
				res.duty_b = sine_point(ofs);
			end else begin
				res.duty_a = sine_point(ofs);
				res.duty_b = sine_point(MICROSTEPS_PER_STEP - ofs);
			end
			case (quad)
				0:       res.pattern = PATTERN_Q0;
				1:       res.pattern = PATTERN_Q1;
				2:       res.pattern = PATTERN_Q2;
				default: res.pattern = PATTERN_Q3;
			endcase
		end
		// release leaves duties and pattern at zero and keeps the position
		res.position  = trk_pos;
		res.at_target = (trk_pos == trk_target);
		return res;
	endfunction

	function automatic plan_row_t req_row(input func_t f, input dir_t d);
		plan_row_t row;
		row = '0;
		row.func = f;
		row.dir  = d;
		return row;
	endfunction

	function automatic plan_row_t typed_row(input func_t f, input dir_t d,
			input logic [DUTY_W-1:0] a, input logic [DUTY_W-1:0] b,
			input logic [PATTERN_W-1:0] pat, input logic [POS_W-1:0] pos, input logic at);
		plan_row_t row;
		row = req_row(f, d);
		row.typed = 1'b1;
		row.want  = '{at_target: at, position: pos, pattern: pat, duty_b: b, duty_a: a};
		return row;
	endfunction

	function automatic plan_row_t write_row(input cfg_idx_t idx, input logic [POS_W-1:0] val);
		plan_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		return row;
	endfunction

	// drop valid and wait until every expected result has been taken
	task automatic drain_requests();
		s_axis_tvalid <= 1'b0;
		while (drive_expect_q.size() != 0) @(posedge clk);
	endtask

	// register writes only happen with the unit idle
	task automatic write_register(input cfg_idx_t idx, input logic [POS_W-1:0] val);
		drain_requests();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_REV_LEN) trk_rev_len = val;
		else trk_target = val;
		@(posedge clk);
	endtask

	// optional gap first, then hold the request until it is taken
	task automatic send_request(input func_t f, input dir_t d, input logic typed,
			input coil_drive_t want);
		coil_drive_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= IN_DATA_W'(d);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = step_drive(f, d);
		// hand-typed rows still advance the tracker but are checked against the typed values
		drive_expect_q.push_back(typed ? want : predicted);
	endtask

	// result side: check each taken result, then decide the next cycle's stall
	always @(posedge clk) begin
		coil_drive_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(coil_drive_t)-1:0];
			if (drive_expect_q.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_MISMATCHES)
					$display("unexpected result: a=%0d b=%0d pat=%h pos=%0d at=%0d",
						got.duty_a, got.duty_b, got.pattern, got.position, got.at_target);
			end else begin
				want = drive_expect_q.pop_front();
				if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
						got.pattern !== want.pattern || got.position !== want.position ||
						got.at_target !== want.at_target) begin
					fail_count++;
					if (fail_count <= SHOWN_MISMATCHES) begin
						$write("mismatch: expected a=%0d b=%0d pat=%h pos=%0d at=%0d, ",
							want.duty_a, want.duty_b, want.pattern, want.position,
							want.at_target);
						$display("got a=%0d b=%0d pat=%h pos=%0d at=%0d",
							got.duty_a, got.duty_b, got.pattern, got.position,
							got.at_target);
					end
				end
			end
		end
		// a stall opens a burst, and stall_left counts down what remains of it
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		plan_row_t        plan [$];
		logic [POS_W-1:0] rev_plan [RANDOM_PHASES];
		logic [POS_W-1:0] tgt;
		dir_t             run_dir;
		func_t            f;
		dir_t             d;

		// hold reset, then release it at a rising edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset values, both wraps, full-length revolution,
		// position left beyond a shortened revolution, one-step revolution
		plan = '{
			typed_row(FUNC_RELEASE, DIR_FWD, 0, 0, PATTERN_OFF, 0, 1),   // release right out of reset
			typed_row(FUNC_STEP, DIR_FWD, 4075, 401, PATTERN_Q0, 1, 0),
			typed_row(FUNC_STEP, DIR_BWD, 4095, 0, PATTERN_Q0, 0, 1),
			typed_row(FUNC_STEP, DIR_BWD, 4075, 401, PATTERN_Q3, 3199, 0), // phase and position wrap back
			typed_row(FUNC_RELEASE, DIR_BWD, 0, 0, PATTERN_OFF, 3199, 0),  // direction ignored
			typed_row(FUNC_STEP, DIR_FWD, 4095, 0, PATTERN_Q0, 0, 1),      // both wrap forward
			write_row(CFG_TARGET, 16'hFFFF),
			write_row(CFG_REV_LEN, 16'h0000),                              // zero length is 65536
			typed_row(FUNC_STEP, DIR_BWD, 4075, 401, PATTERN_Q3, 16'hFFFF, 1),
			typed_row(FUNC_STEP, DIR_FWD, 4095, 0, PATTERN_Q0, 0, 0),
			req_row(FUNC_STEP, DIR_BWD),
			write_row(CFG_REV_LEN, 16'd100),                               // position now far beyond the end
			req_row(FUNC_STEP, DIR_FWD),
			req_row(FUNC_STEP, DIR_BWD),
			write_row(CFG_REV_LEN, 16'd50),
			req_row(FUNC_STEP, DIR_BWD),
			req_row(FUNC_STEP, DIR_BWD),
			write_row(CFG_REV_LEN, 16'd48),                                // position equal to the length
			req_row(FUNC_STEP, DIR_BWD),
			write_row(CFG_TARGET, 16'd0),
			write_row(CFG_REV_LEN, 16'd1),
			req_row(FUNC_STEP, DIR_FWD),
			req_row(FUNC_STEP, DIR_BWD),
			req_row(FUNC_RELEASE, DIR_FWD),
			write_row(CFG_REV_LEN, 16'hFFFF),
			req_row(FUNC_STEP, DIR_BWD),
			req_row(FUNC_STEP, DIR_BWD)
		};
		foreach (plan[i]) begin
			if (plan[i].is_write) write_register(plan[i].reg_idx, plan[i].reg_val);
			else send_request(plan[i].func, plan[i].dir, plan[i].typed, plan[i].want);
		end

		// random part: one revolution length per phase, extremes among them;
		// lowering the length after a long one leaves the position beyond the end
		rev_plan = '{16'd3200, 16'd2, 16'hFFFF, 16'd0, 16'd1, 16'd17,
			POS_W'($urandom_range(3, 300)), POS_W'($urandom)};
		run_dir = DIR_FWD;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// last phase runs with no idling at all
			if (p == RANDOM_PHASES - 1) calm = 1'b1;
			write_register(CFG_REV_LEN, rev_plan[p]);
			// target near the current position so at_target gets hit on the way
			case ($urandom_range(0, 3))
				0:       tgt = trk_pos + POS_W'($urandom_range(0, 24));
				1:       tgt = trk_pos - POS_W'($urandom_range(0, 24));
				2:       tgt = rev_plan[p] - 1'b1;
				default: tgt = POS_W'($urandom);
			endcase
			write_register(CFG_TARGET, tgt);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// steps come in runs of one direction so the position travels
				if ($urandom_range(0, 7) == 0)
					run_dir = (run_dir == DIR_FWD) ? DIR_BWD : DIR_FWD;
				if ($urandom_range(0, 9) == 0) begin
					f = FUNC_RELEASE;
					d = dir_t'($urandom_range(0, 1));
				end else begin
					f = FUNC_STEP;
					d = run_dir;
				end
				send_request(f, d, 1'b0, '0);
			end
		end

		// let the last results out, then a short tail for anything stray
		drain_requests();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && drive_expect_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
src/mcs_pkg.sv
src/microstep_coil_sequencer_unit.sv
sim/tb_top.sv
